// ===== design/jse_pkg.sv =====
// jse_pkg: types, character codes and helpers for the json string escaper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jse_pkg;

  localparam int BURST_MAX = 8;

  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_E2   = 2'd1;
  localparam logic [1:0] PFX_E280 = 2'd2;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] UTF_LEAD   = 8'he2;
  localparam logic [7:0] UTF_MID    = 8'h80;
  localparam logic [7:0] UTF_LS     = 8'ha8;
  localparam logic [7:0] UTF_PS     = 8'ha9;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_LF  = 8'h0a;
  localparam logic [7:0] CTL_FF  = 8'h0c;
  localparam logic [7:0] CTL_CR  = 8'h0d;

  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSL   = 8'h5c;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_TWO   = 8'h32;
  localparam logic [7:0] CHR_EIGHT = 8'h38;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_B     = 8'h62;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_N     = 8'h6e;
  localparam logic [7:0] CHR_R     = 8'h72;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_U     = 8'h75;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } result_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      done;
  } burst_t;

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CHR_ZERO + {4'd0, n};
    end else begin
      r = 8'h57 + {4'd0, n};
    end
    return r;
  endfunction

endpackage

// ===== design/jse_front.sv =====
// jse_front: accepts raw bytes, tracks quote and utf-8 prefix state and
// builds one burst of output bytes per transfer; uses jse_pkg
`timescale 1ns / 1ps

module jse_front
  import jse_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  item_t  item,
  input  logic   q_full,
  output logic   push,
  output burst_t burst
);

  logic       quote_opened;
  logic       quote_opened_next;
  logic [1:0] prefix_held;
  logic [1:0] prefix_held_next;
  logic [1:0] pfx;
  logic       accept;
  burst_t     b;

  function automatic burst_t append(burst_t x, logic [7:0] c);
    burst_t r;
    r = x;
    r.bytes[x.count[2:0]] = c;
    r.count = x.count + 4'd1;
    return r;
  endfunction

  function automatic burst_t flush(burst_t x, logic [1:0] p);
    burst_t r;
    r = x;
    if (p == PFX_E2) begin
      r = append(r, UTF_LEAD);
    end else if (p == PFX_E280) begin
      r = append(r, UTF_LEAD);
      r = append(r, UTF_MID);
    end
    return r;
  endfunction

  function automatic burst_t handle(burst_t x, logic [7:0] c);
    burst_t r;
    r = x;
    if (c < CTRL_LIMIT) begin
      r = append(r, CHR_BSL);
      case (c)
        CTL_BS:  r = append(r, CHR_B);
        CTL_FF:  r = append(r, CHR_F);
        CTL_LF:  r = append(r, CHR_N);
        CTL_CR:  r = append(r, CHR_R);
        CTL_TAB: r = append(r, CHR_T);
        default: begin
          r = append(r, CHR_U);
          r = append(r, CHR_ZERO);
          r = append(r, CHR_ZERO);
          r = append(r, hex_digit(c[7:4]));
          r = append(r, hex_digit(c[3:0]));
        end
      endcase
    end else if (c == CHR_QUOTE) begin
      r = append(r, CHR_BSL);
      r = append(r, CHR_QUOTE);
    end else if (c == CHR_BSL) begin
      r = append(r, CHR_BSL);
      r = append(r, CHR_BSL);
    end else if (c != UTF_LEAD) begin
      r = append(r, c);
    end
    return r;
  endfunction

  function automatic burst_t separator(burst_t x, logic [7:0] last);
    burst_t r;
    r = x;
    r = append(r, CHR_BSL);
    r = append(r, CHR_U);
    r = append(r, CHR_TWO);
    r = append(r, CHR_ZERO);
    r = append(r, CHR_TWO);
    r = append(r, last);
    return r;
  endfunction

  assign accept = item_valid && !q_full;
  assign pfx    = (prefix_held == PFX_E2 || prefix_held == PFX_E280) ? prefix_held : PFX_NONE;

  always_comb begin
    b = '0;
    quote_opened_next = quote_opened;
    prefix_held_next  = pfx;
    if (!quote_opened) begin
      b = append(b, CHR_QUOTE);
      quote_opened_next = 1'b1;
    end
    if (item.cmd) begin
      b = flush(b, pfx);
      b = append(b, CHR_QUOTE);
      b.done = 1'b1;
      quote_opened_next = 1'b0;
      prefix_held_next  = PFX_NONE;
    end else if (pfx == PFX_E2 && item.data_byte == UTF_MID) begin
      prefix_held_next = PFX_E280;
    end else if (pfx == PFX_E280 && item.data_byte == UTF_LS) begin
      b = separator(b, CHR_EIGHT);
      prefix_held_next = PFX_NONE;
    end else if (pfx == PFX_E280 && item.data_byte == UTF_PS) begin
      b = separator(b, CHR_NINE);
      prefix_held_next = PFX_NONE;
    end else begin
      b = flush(b, pfx);
      b = handle(b, item.data_byte);
      prefix_held_next = (item.data_byte == UTF_LEAD) ? PFX_E2 : PFX_NONE;
    end
  end

  assign burst = b;
  assign push  = accept && (b.count != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_opened <= 1'b0;
      prefix_held  <= PFX_NONE;
    end else if (accept) begin
      quote_opened <= quote_opened_next;
      prefix_held  <= prefix_held_next;
    end
  end

  a_burst_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> (burst.count <= 4'(BURST_MAX)))
    else $error("burst longer than eight bytes");
  a_done_ends_quote: assert property (@(posedge clk) disable iff (rst)
    (push && burst.done) |-> (burst.bytes[3'(burst.count - 4'd1)] == CHR_QUOTE))
    else $error("end of string burst does not end in a quote");
  a_prefix_after_open: assert property (@(posedge clk) disable iff (rst)
    (prefix_held != PFX_NONE) |-> quote_opened)
    else $error("prefix held outside an open string");

endmodule

// ===== design/jse_queue.sv =====
// jse_queue: small register queue of bursts between front and back
// uses jse_pkg for the burst type
`timescale 1ns / 1ps

module jse_queue
  import jse_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   nonempty,
  output burst_t head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  burst_t        slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full     = (fill == CW'(QDEPTH));
  assign nonempty = (fill != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> !pop)
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(QDEPTH))
    else $error("queue fill out of range");

endmodule

// ===== design/jse_back.sv =====
// jse_back: walks the head burst one byte per cycle into the result register while result_stall is low
// uses jse_pkg for burst and result types
`timescale 1ns / 1ps

module jse_back
  import jse_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_nonempty,
  input  burst_t  head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [2:0] pos;
  logic       load;
  logic       last;

  assign load = q_nonempty && (!result_valid || !result_stall);
  assign last = (({1'b0, pos} + 4'd1) == head.count);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        pos          <= last ? 3'd0 : pos + 3'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte    <= head.bytes[pos];
      result.run_last    <= last;
      result.string_done <= last && head.done;
    end
  end

  a_pos_in_burst: assert property (@(posedge clk) disable iff (rst)
    q_nonempty |-> ({1'b0, pos} < head.count))
    else $error("byte position past end of burst");
  a_done_is_last_quote: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.string_done) |-> (result.run_last && result.out_byte == CHR_QUOTE))
    else $error("string done not on closing quote");
  a_pos_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !q_nonempty |-> (pos == 3'd0))
    else $error("byte position left over with empty queue");

endmodule

// ===== design/json_string_escaper_unit.sv =====
// Escapes a raw byte stream into a quoted JSON string literal. An input
// transfer carries one string byte or an end-of-string mark; every transfer
// is turned combinationally into a burst of zero to eight output bytes, which a
// queue of QDEPTH bursts hands to a serializer that sends one output byte per
// cycle while result_stall is low. Input is taken every cycle while the queue
// has room, so the sustained rate is one input transfer per cycle for bytes that
// pass unchanged while the output is not stalled, and lower for inputs that expand
// to more than one output byte (up to 8 for an escape after a broken utf-8 prefix).
// run_last marks the final byte of each burst; string_done marks the closing quote.
// Each output byte is held in a queue slot and then in the result register.
// depends on jse_pkg, jse_front, jse_queue and jse_back
`timescale 1ns / 1ps

module json_string_escaper_unit
  import jse_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic   push;
  burst_t burst;
  logic   pop;
  logic   q_full;
  logic   q_nonempty;
  burst_t head;

  assign item_stall = q_full;

  jse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .burst      (burst)
  );

  jse_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (burst),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head)
  );

  jse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_nonempty   (q_nonempty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
